/* sv/cbcr_pkg.sv */
// Shared constants, types and register codes of the cell balance and charge rate unit.
`default_nettype none

package cbcr_pkg;

  localparam int MAX_BOARDS  = 12;
  localparam int MAX_CELLS   = 12;
  localparam int BOARD_IDX_W = (MAX_BOARDS > 1) ? $clog2(MAX_BOARDS) : 1;
  localparam int CELL_IDX_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  // Read counter of the emit pass reaches the board count itself.
  localparam int RD_CNT_W    = BOARD_IDX_W + 1;

  localparam int VOLT_W      = 16;
  localparam int LIMIT_W     = VOLT_W + 1;
  localparam int MASK_BITS   = 12;
  localparam int BOARD_NUM_W = 4;
  localparam int GEOM_W      = 4;
  localparam int RATE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [VOLT_W-1:0] OVERVOLTAGE_RST = 16'd42500;
  localparam logic [VOLT_W-1:0] STOP_CHARGE_RST = 16'd42000;
  localparam logic [VOLT_W-1:0] SLOW_CHARGE_RST = 16'd41000;
  localparam logic [VOLT_W-1:0] MARGIN_RST      = 16'd100;
  localparam logic [GEOM_W-1:0] BOARD_COUNT_RST = 4'd12;
  localparam logic [GEOM_W-1:0] CELLS_RST       = 4'd12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERVOLTAGE     = 3'd0,
    REG_STOP_CHARGE     = 3'd1,
    REG_SLOW_CHARGE     = 3'd2,
    REG_BALANCE_MARGIN  = 3'd3,
    REG_BOARD_COUNT     = 3'd4,
    REG_CELLS_PER_BOARD = 3'd5
  } cfg_reg_e;

  typedef enum logic [RATE_W-1:0] {
    RATE_STOP   = 2'd0,
    RATE_SLOW   = 2'd1,
    RATE_NORMAL = 2'd2
  } charge_rate_e;

  typedef struct packed {
    logic [VOLT_W-1:0] overvoltage_limit;
    logic [VOLT_W-1:0] stop_charge_limit;
    logic [VOLT_W-1:0] slow_charge_limit;
    logic [VOLT_W-1:0] balance_margin;
    logic [GEOM_W-1:0] board_count;
    logic [GEOM_W-1:0] cells_per_board;
  } cfg_t;

  // One finished run waiting for its emit pass.
  typedef struct packed {
    charge_rate_e            rate;
    logic [VOLT_W-1:0]       lowest;
    logic [BOARD_IDX_W-1:0]  boards_last;
    logic [CELL_IDX_W-1:0]   cells_last;
  } run_desc_t;

  typedef struct packed {
    logic                    en;
    logic [BOARD_IDX_W-1:0]  row;
    logic [CELL_IDX_W-1:0]   lane;
    logic [VOLT_W-1:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  typedef struct packed {
    logic [BOARD_NUM_W-1:0] board_number;
    logic [MASK_BITS-1:0]   discharge_mask;
    logic [RATE_W-1:0]      charge_rate;
    logic [VOLT_W-1:0]      lowest_voltage;
    logic                   last_board;
  } result_t;

endpackage

`default_nettype wire

/* sv/cbcr_if.sv */
// Handshake interfaces for cell voltages, board results and register writes.
`default_nettype none

interface cbcr_cell_if import cbcr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] cell_voltage;

  modport source (output valid, output cell_voltage, input ready);
  modport sink   (input valid, input cell_voltage, output ready);
endinterface

interface cbcr_result_if import cbcr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [BOARD_NUM_W-1:0] board_number;
  logic [MASK_BITS-1:0]   discharge_mask;
  logic [RATE_W-1:0]      charge_rate;
  logic [VOLT_W-1:0]      lowest_voltage;
  logic                   last_board;

  modport source (output valid, output board_number, output discharge_mask,
                  output charge_rate, output lowest_voltage, output last_board,
                  input ready);
  modport sink   (input valid, input board_number, input discharge_mask,
                  input charge_rate, input lowest_voltage, input last_board,
                  output ready);
endinterface

interface cbcr_cfg_if import cbcr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/cbcr_front.sv */
// Load side: accepts cell voltages, writes them to the store and folds minimum and rate flags.
`default_nettype none

module cbcr_front import cbcr_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  cbcr_cell_if.sink              cell_i,
  input  cfg_t                   cfg_i,
  input  queue_stat_t            qstat_i,
  input  wire [RD_CNT_W-1:0]     rd_board_i,
  output store_wr_t              store_wr_o,
  output logic                   push_o,
  output run_desc_t              desc_o
);

  logic [BOARD_IDX_W-1:0] board_q, board_d;
  logic [CELL_IDX_W-1:0]  cell_q, cell_d;
  logic [VOLT_W-1:0]      min_q, min_d;
  logic                   stop_q, stop_d;
  logic                   slow_q, slow_d;

  logic [GEOM_W:0]        boards_ext, cells_ext;
  logic [BOARD_IDX_W-1:0] boards_last;
  logic [CELL_IDX_W-1:0]  cells_last;
  logic                   accept, run_end;
  logic [VOLT_W-1:0]      v, min_nx;
  logic                   stop_nx, slow_nx;
  charge_rate_e           rate_nx;

  assign boards_ext = {1'b0, cfg_i.board_count};
  assign cells_ext  = {1'b0, cfg_i.cells_per_board};

  // Zero acts as one, values above the store geometry saturate.
  always_comb begin
    priority if (boards_ext == '0) begin
      boards_last = '0;
    end else if (boards_ext > (GEOM_W+1)'(MAX_BOARDS)) begin
      boards_last = BOARD_IDX_W'(MAX_BOARDS - 1);
    end else begin
      boards_last = BOARD_IDX_W'(boards_ext - 1'b1);
    end
    priority if (cells_ext == '0) begin
      cells_last = '0;
    end else if (cells_ext > (GEOM_W+1)'(MAX_CELLS)) begin
      cells_last = CELL_IDX_W'(MAX_CELLS - 1);
    end else begin
      cells_last = CELL_IDX_W'(cells_ext - 1'b1);
    end
  end

  // A row may be reloaded only after the emit pass of the queued run has read it.
  assign cell_i.ready = qstat_i.empty ||
                        (!qstat_i.full && ({1'b0, board_q} < rd_board_i));
  assign accept = cell_i.valid && cell_i.ready;
  assign v      = cell_i.cell_voltage;

  assign min_nx  = (v < min_q) ? v : min_q;
  assign stop_nx = stop_q || (v > cfg_i.overvoltage_limit) || (v > cfg_i.stop_charge_limit);
  assign slow_nx = slow_q || (v > cfg_i.slow_charge_limit);
  assign run_end = (board_q == boards_last) && (cell_q == cells_last);

  assign store_wr_o.en   = accept;
  assign store_wr_o.row  = board_q;
  assign store_wr_o.lane = cell_q;
  assign store_wr_o.data = v;

  assign push_o             = accept && run_end;
  assign desc_o.rate        = rate_nx;
  assign desc_o.lowest      = min_nx;
  assign desc_o.boards_last = boards_last;
  assign desc_o.cells_last  = cells_last;
  always_comb begin
    priority if (stop_nx) begin
      rate_nx = RATE_STOP;
    end else if (slow_nx) begin
      rate_nx = RATE_SLOW;
    end else begin
      rate_nx = RATE_NORMAL;
    end
  end

  always_comb begin
    board_d = board_q;
    cell_d  = cell_q;
    min_d   = min_q;
    stop_d  = stop_q;
    slow_d  = slow_q;
    if (accept) begin
      if (run_end) begin
        board_d = '0;
        cell_d  = '0;
        min_d   = '1;
        stop_d  = 1'b0;
        slow_d  = 1'b0;
      end else begin
        min_d  = min_nx;
        stop_d = stop_nx;
        slow_d = slow_nx;
        if (cell_q == cells_last) begin
          cell_d  = '0;
          board_d = board_q + 1'b1;
        end else begin
          cell_d = cell_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_q <= '0;
      cell_q  <= '0;
      min_q   <= '1;
      stop_q  <= 1'b0;
      slow_q  <= 1'b0;
    end else begin
      board_q <= board_d;
      cell_q  <= cell_d;
      min_q   <= min_d;
      stop_q  <= stop_d;
      slow_q  <= slow_d;
    end
  end

endmodule

`default_nettype wire

/* sv/cbcr_queue.sv */
// Short queue of finished runs between the load side and the emit side.
`default_nettype none

module cbcr_queue import cbcr_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push_i,
  input  run_desc_t   desc_i,
  input  wire         pop_i,
  output run_desc_t   head_o,
  output queue_stat_t stat_o
);

  run_desc_t          entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign head_o       = entries_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/cbcr_back.sv */
// Emit side: holds the voltage store and produces one discharge mask per board.
`default_nettype none

module cbcr_back import cbcr_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire [VOLT_W-1:0]      margin_i,
  input  store_wr_t             store_wr_i,
  input  wire                   head_valid_i,
  input  run_desc_t             head_i,
  output logic                  pop_o,
  output logic [RD_CNT_W-1:0]   rd_board_o,
  cbcr_result_if.source         result_o
);

  // One row per board, one lane per cell.
  logic [MAX_CELLS-1:0][VOLT_W-1:0] store_q [MAX_BOARDS];

  logic [RD_CNT_W-1:0]              rd_board_q, rd_board_d;
  logic [MAX_CELLS-1:0][VOLT_W-1:0] row_q;
  logic                             s1_vld_q, s1_vld_d;
  logic [BOARD_IDX_W-1:0]           s1_board_q;
  logic                             out_vld_q, out_vld_d;
  result_t                          out_q;

  logic                             out_load, issue, s1_last;
  logic [LIMIT_W-1:0]               limit;
  logic [MASK_BITS-1:0]             mask;

  assign out_load = s1_vld_q && (!out_vld_q || result_o.ready);
  assign issue    = head_valid_i && (rd_board_q <= {1'b0, head_i.boards_last}) &&
                    (!s1_vld_q || out_load);
  assign s1_last  = (s1_board_q == head_i.boards_last);
  assign pop_o    = out_load && s1_last;
  assign rd_board_o = rd_board_q;

  // The sum keeps its carry so a high minimum plus margin never wraps.
  assign limit = {1'b0, head_i.lowest} + {1'b0, margin_i};

  for (genvar c = 0; c < MASK_BITS; c++) begin : g_mask
    if (c < MAX_CELLS) begin : g_cell
      assign mask[c] = (CELL_IDX_W'(c) <= head_i.cells_last) &&
                       ({1'b0, row_q[c]} > limit);
    end else begin : g_none
      assign mask[c] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_wr_i.en) begin
      store_q[store_wr_i.row][store_wr_i.lane] <= store_wr_i.data;
    end
    if (issue) begin
      row_q      <= store_q[rd_board_q[BOARD_IDX_W-1:0]];
      s1_board_q <= rd_board_q[BOARD_IDX_W-1:0];
    end
    if (out_load) begin
      out_q.board_number   <= BOARD_NUM_W'(s1_board_q);
      out_q.discharge_mask <= mask;
      out_q.charge_rate    <= head_i.rate;
      out_q.lowest_voltage <= head_i.lowest;
      out_q.last_board     <= s1_last;
    end
  end

  always_comb begin
    rd_board_d = rd_board_q;
    if (pop_o) begin
      rd_board_d = '0;
    end else if (issue) begin
      rd_board_d = rd_board_q + 1'b1;
    end
    s1_vld_d = s1_vld_q;
    if (issue) begin
      s1_vld_d = 1'b1;
    end else if (out_load) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (result_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_board_q <= '0;
      s1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      rd_board_q <= rd_board_d;
      s1_vld_q   <= s1_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  assign result_o.valid          = out_vld_q;
  assign result_o.board_number   = out_q.board_number;
  assign result_o.discharge_mask = out_q.discharge_mask;
  assign result_o.charge_rate    = out_q.charge_rate;
  assign result_o.lowest_voltage = out_q.lowest_voltage;
  assign result_o.last_board     = out_q.last_board;

endmodule

`default_nettype wire

/* sv/cell_balance_charge_rate_unit.sv */
// Top level of the cell balance and charge rate unit with its register file.
//
//   channel   direction  payload
//   cell_i    in         cell_voltage, one request per cell, board-major
//   result_o  out        board_number, discharge_mask, charge_rate,
//                        lowest_voltage, last_board, one per board
//   cfg_i     in         index, data; always ready
//
// Cells load one per cycle while cell_i is ready. After a run's last cell
// the run passes the run queue, row-read stage and output register; results
// then follow one per cycle unless stalled (single store read port, one row).
// The next run loads while results drain; a cell waits only while its board
// row has not yet been read for the queued run, or two runs are queued.
// Reset clears counters, flags and queue; the store is not cleared.
// A stalled result holds its output register and the emit pass behind it.
`default_nettype none

module cell_balance_charge_rate_unit import cbcr_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  cbcr_cell_if.sink      cell_i,
  cbcr_result_if.source  result_o,
  cbcr_cfg_if.sink       cfg_i
);

  cfg_t                cfg_q;
  store_wr_t           store_wr;
  logic                push, pop;
  run_desc_t           desc, head;
  queue_stat_t         qstat;
  logic [RD_CNT_W-1:0] rd_board;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overvoltage_limit <= OVERVOLTAGE_RST;
      cfg_q.stop_charge_limit <= STOP_CHARGE_RST;
      cfg_q.slow_charge_limit <= SLOW_CHARGE_RST;
      cfg_q.balance_margin    <= MARGIN_RST;
      cfg_q.board_count       <= BOARD_COUNT_RST;
      cfg_q.cells_per_board   <= CELLS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_OVERVOLTAGE:     cfg_q.overvoltage_limit <= cfg_i.data[VOLT_W-1:0];
        REG_STOP_CHARGE:     cfg_q.stop_charge_limit <= cfg_i.data[VOLT_W-1:0];
        REG_SLOW_CHARGE:     cfg_q.slow_charge_limit <= cfg_i.data[VOLT_W-1:0];
        REG_BALANCE_MARGIN:  cfg_q.balance_margin    <= cfg_i.data[VOLT_W-1:0];
        REG_BOARD_COUNT:     cfg_q.board_count       <= cfg_i.data[GEOM_W-1:0];
        REG_CELLS_PER_BOARD: cfg_q.cells_per_board   <= cfg_i.data[GEOM_W-1:0];
        default: ;
      endcase
    end
  end

  cbcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_i     (cell_i),
    .cfg_i      (cfg_q),
    .qstat_i    (qstat),
    .rd_board_i (rd_board),
    .store_wr_o (store_wr),
    .push_o     (push),
    .desc_o     (desc)
  );

  cbcr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  cbcr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .margin_i     (cfg_q.balance_margin),
    .store_wr_i   (store_wr),
    .head_valid_i (!qstat.empty),
    .head_i       (head),
    .pop_o        (pop),
    .rd_board_o   (rd_board),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

/* sv/cbcr_checker.sv */
// Port-level checks of the result stream, bound to the top level.
`default_nettype none

module cbcr_checker import cbcr_pkg::*; (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   out_valid_i,
  input wire                   out_ready_i,
  input wire [BOARD_NUM_W-1:0] board_number_i,
  input wire [MASK_BITS-1:0]   discharge_mask_i,
  input wire [RATE_W-1:0]      charge_rate_i,
  input wire [VOLT_W-1:0]      lowest_voltage_i,
  input wire                   last_board_i
);

  logic [BOARD_NUM_W-1:0] expect_board_q;
  logic                   mid_run_q;
  logic [VOLT_W-1:0]      lowest_prev_q;
  logic                   out_accept;

  assign out_accept = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_board_q <= '0;
      mid_run_q      <= 1'b0;
      lowest_prev_q  <= '0;
    end else if (out_accept) begin
      expect_board_q <= last_board_i ? '0 : board_number_i + 1'b1;
      mid_run_q      <= !last_board_i;
      lowest_prev_q  <= lowest_voltage_i;
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(board_number_i) && $stable(discharge_mask_i) &&
      $stable(charge_rate_i) && $stable(lowest_voltage_i) && $stable(last_board_i))
    else $error("result payload changed while stalled");

  a_board_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> board_number_i == expect_board_q)
    else $error("board results out of order");

  a_run_minimum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mid_run_q |-> lowest_voltage_i == lowest_prev_q)
    else $error("lowest voltage changed within one run");

endmodule

bind cell_balance_charge_rate_unit cbcr_checker u_cbcr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .board_number_i   (result_o.board_number),
  .discharge_mask_i (result_o.discharge_mask),
  .charge_rate_i    (result_o.charge_rate),
  .lowest_voltage_i (result_o.lowest_voltage),
  .last_board_i     (result_o.last_board)
);

`default_nettype wire

/* tb/cell_balance_charge_rate_unit_tb.sv */
// Self-checking testbench for the cell balance and charge rate unit.
`default_nettype none

module cell_balance_charge_rate_unit_tb import cbcr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_CELLS = 75;

  // Predicts the per-board results of each run and checks the ones the block returns.
  class cbcr_scoreboard;
    cfg_t              regs;
    logic [VOLT_W-1:0] cell_volts [MAX_BOARDS][MAX_CELLS];
    logic [VOLT_W-1:0] run_lowest;
    bit                stop_seen;
    bit                slow_seen;
    int                load_pos;
    result_t           pending_boards [$];
    int                errors;

    function new();
      regs.overvoltage_limit = OVERVOLTAGE_RST;
      regs.stop_charge_limit = STOP_CHARGE_RST;
      regs.slow_charge_limit = SLOW_CHARGE_RST;
      regs.balance_margin    = MARGIN_RST;
      regs.board_count       = BOARD_COUNT_RST;
      regs.cells_per_board   = CELLS_RST;
      errors = 0;
      restart_run();
    endfunction

    function void restart_run();
      run_lowest = '1;
      stop_seen  = 1'b0;
      slow_seen  = 1'b0;
      load_pos   = 0;
    endfunction

    // A geometry of zero acts as one; values past the maximum saturate.
    function int clamp_geom(logic [GEOM_W-1:0] v, int hi);
      if (v == '0) return 1;
      return (int'(v) > hi) ? hi : int'(v);
    endfunction

    function int boards();
      return clamp_geom(regs.board_count, MAX_BOARDS);
    endfunction

    function int cells();
      return clamp_geom(regs.cells_per_board, MAX_CELLS);
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_OVERVOLTAGE:     regs.overvoltage_limit = d;
        REG_STOP_CHARGE:     regs.stop_charge_limit = d;
        REG_SLOW_CHARGE:     regs.slow_charge_limit = d;
        REG_BALANCE_MARGIN:  regs.balance_margin    = d;
        REG_BOARD_COUNT:     regs.board_count       = d[GEOM_W-1:0];
        REG_CELLS_PER_BOARD: regs.cells_per_board   = d[GEOM_W-1:0];
        default: ;
      endcase
    endfunction

    function void load_cell(logic [VOLT_W-1:0] v);
      int                 nb;
      int                 nc;
      int                 total;
      logic [LIMIT_W-1:0] limit;
      charge_rate_e       rate;
      result_t            r;
      nb    = boards();
      nc    = cells();
      total = nb * nc;
      if (load_pos >= total) load_pos = total - 1;
      cell_volts[load_pos / nc][load_pos % nc] = v;
      if (v < run_lowest) run_lowest = v;
      if (v > regs.overvoltage_limit || v > regs.stop_charge_limit) stop_seen = 1'b1;
      if (v > regs.slow_charge_limit) slow_seen = 1'b1;
      if (load_pos + 1 < total) begin
        load_pos++;
        return;
      end
      rate  = stop_seen ? RATE_STOP : (slow_seen ? RATE_SLOW : RATE_NORMAL);
      // The threshold is kept at 17 bits so a large margin cannot wrap.
      limit = {1'b0, run_lowest} + {1'b0, regs.balance_margin};
      for (int b = 0; b < nb; b++) begin
        r = '0;
        r.board_number = BOARD_NUM_W'(b);
        for (int c = 0; c < nc && c < MASK_BITS; c++) begin
          if ({1'b0, cell_volts[b][c]} > limit) r.discharge_mask[c] = 1'b1;
        end
        r.charge_rate    = rate;
        r.lowest_voltage = run_lowest;
        r.last_board     = (b + 1 == nb);
        pending_boards.push_back(r);
      end
      restart_run();
    endfunction

    task report(string what);
      $display("[%0t] ERROR: %s", $time, what);
      errors++;
    endtask

    task compare(string field, logic [VOLT_W-1:0] got, logic [VOLT_W-1:0] want);
      if (got !== want) report($sformatf("%s is %0h, expected %0h", field, got, want));
    endtask

    task check_board(result_t got);
      result_t want;
      if (pending_boards.size() == 0) begin
        report($sformatf("result for board %0d with no request pending", got.board_number));
        return;
      end
      want = pending_boards.pop_front();
      compare("board_number", got.board_number, want.board_number);
      compare("discharge_mask", got.discharge_mask, want.discharge_mask);
      compare("charge_rate", got.charge_rate, want.charge_rate);
      compare("lowest_voltage", got.lowest_voltage, want.lowest_voltage);
      compare("last_board", got.last_board, want.last_board);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm_send;
  bit   calm_recv;
  int   random_cells;

  cbcr_scoreboard board_sb = new();

  cbcr_cell_if   cell_if ();
  cbcr_result_if res_if ();
  cbcr_cfg_if    cfg_if ();

  cell_balance_charge_rate_unit uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cell_i   (cell_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  always #5ns clk = ~clk;

  function automatic int gap_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [VOLT_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VOLT_W'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_margin();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return CFG_DATA_W'($urandom);
    return CFG_DATA_W'($urandom_range(0, 300));
  endfunction

  // Mostly small geometries; zero and values past the maximum now and then.
  function automatic logic [CFG_DATA_W-1:0] pick_geom();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 7) return CFG_DATA_W'($urandom_range(1, 3));
    if (r < 9) return CFG_DATA_W'($urandom_range(4, 12));
    return CFG_DATA_W'($urandom_range(12, 15));
  endfunction

  // Voltages cluster around one level per run so thresholds and masks get exercised.
  function automatic logic [VOLT_W-1:0] pick_volt(int center);
    int r;
    int v;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return VOLT_W'($urandom);
    v = center - 150 + $urandom_range(0, 300);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return VOLT_W'(v);
  endfunction

  task automatic send_cell(input logic [VOLT_W-1:0] v);
    int gap;
    gap = gap_len(calm_send);
    if (gap > 0) begin
      cell_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_if.valid        <= 1'b1;
    cell_if.cell_voltage <= v;
    do @(posedge clk); while (!cell_if.ready);
    board_sb.load_cell(v);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    board_sb.set_reg(idx, d);
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] ov, input logic [CFG_DATA_W-1:0] stop,
                           input logic [CFG_DATA_W-1:0] slow, input logic [CFG_DATA_W-1:0] margin,
                           input logic [CFG_DATA_W-1:0] nb, input logic [CFG_DATA_W-1:0] nc);
    write_reg(REG_OVERVOLTAGE, ov);
    write_reg(REG_STOP_CHARGE, stop);
    write_reg(REG_SLOW_CHARGE, slow);
    write_reg(REG_BALANCE_MARGIN, margin);
    write_reg(REG_BOARD_COUNT, nb);
    write_reg(REG_CELLS_PER_BOARD, nc);
    cfg_if.valid <= 1'b0;
  endtask

  // Holds the sender until every predicted board result has come back.
  task automatic drain_results();
    cell_if.valid <= 1'b0;
    while (board_sb.pending_boards.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin : result_sink
    int      stall;
    result_t got;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        got.board_number   = res_if.board_number;
        got.discharge_mask = res_if.discharge_mask;
        got.charge_rate    = res_if.charge_rate;
        got.lowest_voltage = res_if.lowest_voltage;
        got.last_board     = res_if.last_board;
        board_sb.check_board(got);
      end
      if (stall > 0) stall--;
      else stall = gap_len(calm_recv);
      res_if.ready <= (stall == 0);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int runs;
    int total;
    int center;
    rst_n                <= 1'b0;
    cell_if.valid        <= 1'b0;
    cell_if.cell_voltage <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= REG_OVERVOLTAGE;
    cfg_if.data          <= '0;
    calm_send = 1'b0;
    calm_recv = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One cell per run against the reset thresholds: each request ends a run.
    write_reg(REG_BOARD_COUNT, 1);
    write_reg(REG_CELLS_PER_BOARD, 1);
    cfg_if.valid <= 1'b0;
    send_cell(16'd42501);
    send_cell(16'd42001);
    send_cell(16'd41001);
    send_cell(16'd41000);
    send_cell(16'd0);
    send_cell(16'hFFFF);
    drain_results();

    // Overvoltage alone forces stop; zero margin marks any cell above the minimum.
    write_all(16'd30000, 16'hFFFF, 16'hFFFF, 16'd0, 2, 2);
    send_cell(16'd30001);
    send_cell(16'd5);
    send_cell(16'd6);
    send_cell(16'd5);
    drain_results();
    send_cell(16'd7);
    send_cell(16'd7);
    send_cell(16'd7);
    send_cell(16'd7);
    drain_results();

    // Zero boards act as one and fifteen cells as twelve. With a minimum of one and
    // the largest margin, a threshold that wraps would mark every cell.
    write_all(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 0, 15);
    send_cell(16'd1);
    send_cell(16'hFFFF);
    send_cell(16'h5555);
    send_cell(16'hAAAA);
    send_cell(16'h8000);
    send_cell(16'h7FFF);
    send_cell(16'd2);
    send_cell(16'hFFFE);
    send_cell(16'h00FF);
    send_cell(16'hFF00);
    send_cell(16'h0F0F);
    send_cell(16'hF0F0);
    drain_results();

    random_cells = 0;
    while (random_cells < RANDOM_CELLS) begin
      write_all(pick_limit(), pick_limit(), pick_limit(), pick_margin(), pick_geom(),
                pick_geom());
      runs = $urandom_range(1, 3);
      repeat (runs) begin
        if (random_cells >= RANDOM_CELLS) break;
        calm_send = ($urandom_range(0, 3) == 0);
        calm_recv = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
          0:       center = $urandom_range(0, 65535);
          1:       center = board_sb.regs.slow_charge_limit;
          2:       center = board_sb.regs.stop_charge_limit;
          default: center = board_sb.regs.overvoltage_limit;
        endcase
        total = board_sb.boards() * board_sb.cells();
        repeat (total) send_cell(pick_volt(center));
        random_cells += total;
        if ($urandom_range(0, 4) == 0) drain_results();
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (board_sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
